FILE: sv/odacc_pkg.sv
`timescale 1ns / 1ps
package odacc_pkg;

    localparam int FRAME_W     = 512;
    localparam int FRAME_H     = 512;
    localparam int WIN_W       = 512;
    localparam int WIN_H       = 512;
    localparam int FRAME_WORDS = FRAME_W * FRAME_H;
    localparam int ADDR_W      = 18;
    localparam int PIX_W       = 23;
    localparam int PX_LIM      = (WIN_W < FRAME_W) ? WIN_W : FRAME_W;
    localparam int PY_LIM      = (WIN_H < FRAME_H) ? WIN_H : FRAME_H;
    localparam int DRAW_AFTER  = 50;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = 2;

    localparam logic [23:0]        WORD_MAX = 24'hFFFFFF;
    localparam logic signed [31:0] TWO_Q28  = 32'sh2000_0000;
    localparam logic signed [64:0] FOUR_Q56 = 65'sh0_0400_0000_0000_0000;
    localparam logic signed [64:0] HALF_Q28 = 65'sh0_0000_0000_0800_0000;

    localparam logic [3:0] CFG_SCALE_X  = 4'd0;
    localparam logic [3:0] CFG_SCALE_Y  = 4'd1;
    localparam logic [3:0] CFG_OFFSET_X = 4'd2;
    localparam logic [3:0] CFG_OFFSET_Y = 4'd3;
    localparam logic [3:0] CFG_ORIGIN_X = 4'd4;
    localparam logic [3:0] CFG_ORIGIN_Y = 4'd5;
    localparam logic [3:0] CFG_BRIGHT   = 4'd6;
    localparam logic [3:0] CFG_MAX_ITER = 4'd7;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] point_re;
        logic signed [31:0] point_im;
        logic [17:0]        read_addr;
    } in_item_t;

    typedef struct packed {
        logic [23:0] read_data;
        logic [15:0] hits;
        logic        escaped;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        scale_x;
        logic [31:0]        scale_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [8:0]         origin_x;
        logic [8:0]         origin_y;
        logic [23:0]        brightness_step;
        logic [15:0]        max_iter;
    } cfg_t;

    // A classified item as it waits between the front and the orbit engine.
    typedef struct packed {
        logic               kind;
        logic               skip;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [ADDR_W-1:0]  addr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    // Q.44 to integer, nearest, ties away from zero.
    function automatic logic signed [PIX_W-1:0] round_q44(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] sum;
        logic [21:0] r;
        mag = v[65] ? 66'(-v) : 66'(v);
        sum = mag + 66'h0_0000_0800_0000_0000;
        r   = sum[65:44];
        return v[65] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

endpackage

FILE: sv/orbit_density_accumulator_core.sv
`timescale 1ns / 1ps
// Orbit-density accumulator. Items enter through a queue-like port: an item is
// taken when push is high and full is low. A trace item iterates z = z^2 + c
// from its start point and adds brightness_step, saturating, to every frame
// word that an orbit point past index 50 lands on inside the window. A read
// item returns one frame word. Each item gives one result, shown while empty
// is low and taken when pop is high.
// Each orbit step of a trace passes through the multiply state and then the
// evaluate state, and each drawn point adds a frame read and a frame write;
// a read item passes through a frame read state before its result is shown.
// The front buffers up to four items, so the sender keeps going while the
// engine works or while a result waits for pop; full rises only when that
// queue is full or during the clear pass.
// After reset the whole frame (262144 words) is cleared at one word a cycle
// with full held high. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while idle; the block does not check.
module orbit_density_accumulator_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  odacc_pkg::in_item_t   in_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output odacc_pkg::out_item_t  out_item,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import odacc_pkg::*;

    cfg_t      cfg_reg;
    cmd_chan_t chan;
    logic      cmd_pop;
    logic      clearing;
    logic      q_full;
    logic      res_valid;

    // Hold off the sender during the clear pass.
    assign full  = q_full || clearing;
    assign empty = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_x         <= 32'h0100_0000;
            cfg_reg.scale_y         <= 32'h0100_0000;
            cfg_reg.offset_x        <= 32'sh0100_0000;
            cfg_reg.offset_y        <= 32'sh0100_0000;
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.brightness_step <= 24'h010101;
            cfg_reg.max_iter        <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE_X:  cfg_reg.scale_x         <= cfg_data;
                CFG_SCALE_Y:  cfg_reg.scale_y         <= cfg_data;
                CFG_OFFSET_X: cfg_reg.offset_x        <= cfg_data;
                CFG_OFFSET_Y: cfg_reg.offset_y        <= cfg_data;
                CFG_ORIGIN_X: cfg_reg.origin_x        <= cfg_data[8:0];
                CFG_ORIGIN_Y: cfg_reg.origin_y        <= cfg_data[8:0];
                CFG_BRIGHT:   cfg_reg.brightness_step <= cfg_data[23:0];
                CFG_MAX_ITER: cfg_reg.max_iter        <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    odacc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && !clearing),
        .item    (in_item),
        .full    (q_full),
        .cmd_pop (cmd_pop),
        .chan    (chan)
    );

    odacc_orbit u_orbit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .chan      (chan),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (out_item)
    );

endmodule

FILE: sv/odacc_front.sv
`timescale 1ns / 1ps
module odacc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  odacc_pkg::in_item_t item,
    output logic                full,
    input  logic                cmd_pop,
    output odacc_pkg::cmd_chan_t chan
);
    import odacc_pkg::*;

    cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;
    logic               do_push;
    cmd_t               cls;

    // Traces whose start lies outside [-2,2] are marked so the engine skips them.
    always_comb
    begin
        cls.kind = item.kind;
        cls.cx   = item.point_re;
        cls.cy   = item.point_im;
        cls.addr = item.read_addr;
        cls.skip = (item.point_re < -TWO_Q28) || (item.point_re > TWO_Q28) ||
                   (item.point_im < -TWO_Q28) || (item.point_im > TWO_Q28);
    end

    assign full      = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign do_push   = push && !full;
    assign chan.valid = (count_reg != '0);
    assign chan.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: sv/odacc_orbit.sv
`timescale 1ns / 1ps
module odacc_orbit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  odacc_pkg::cfg_t      cfg,
    input  odacc_pkg::cmd_chan_t chan,
    output logic                 cmd_pop,
    output logic                 clearing,
    input  logic                 pop,
    output logic                 res_valid,
    output odacc_pkg::out_item_t res
);
    import odacc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL, S_EVAL, S_RD, S_WR, S_RRD, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [16:0]        k_reg, k_next;
    logic signed [31:0] zx_reg, zx_next, zy_reg, zy_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [63:0] xx_reg, yy_reg, xy_reg, dx_reg, dy_reg;
    logic signed [63:0] xx_next, yy_next, xy_next, dx_next, dy_next;
    logic [15:0]        hits_reg, hits_next;
    logic               esc_reg, esc_next;
    logic               kind_reg, kind_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               res_valid_reg, res_valid_next;
    out_item_t          res_reg, res_next;
    logic [23:0]        mem_q_reg;
    logic [23:0]        frame_mem [FRAME_WORDS];

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [23:0]        mem_wdata;
    logic signed [64:0] r2, tx, ty;
    logic signed [65:0] vx, vy;
    logic signed [PIX_W-1:0] px, py;
    logic               in_win;

    always_comb
    begin
        r2 = 65'(xx_reg) + 65'(yy_reg);
        tx = 65'(xx_reg) - 65'(yy_reg) + HALF_Q28;
        ty = (65'(xy_reg) <<< 1) + HALF_Q28;
        vx = 66'(dx_reg) + (66'(cfg.offset_x) <<< 28);
        vy = (66'(cfg.offset_y) <<< 28) - 66'(dy_reg);
        px = round_q44(vx);
        py = round_q44(vy);
        in_win = (px > $signed({14'd0, cfg.origin_x})) && (px < PIX_W'(PX_LIM)) &&
                 (py > $signed({14'd0, cfg.origin_y})) && (py < PIX_W'(PY_LIM));
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = WORD_MAX;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_WR)
        begin
            mem_we = 1'b1;
            if ((WORD_MAX - mem_q_reg) > cfg.brightness_step)
            begin
                mem_wdata = mem_q_reg + cfg.brightness_step;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        hits_next      = hits_reg;
        esc_next       = esc_reg;
        kind_next      = kind_reg;
        rd_ok_next     = rd_ok_reg;
        addr_next      = addr_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(FRAME_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (chan.valid)
                begin
                    cmd_pop    = 1'b1;
                    kind_next  = chan.cmd.kind;
                    addr_next  = chan.cmd.addr;
                    rd_ok_next = (32'(chan.cmd.addr) < 32'(FRAME_WORDS));
                    cx_next    = chan.cmd.cx;
                    cy_next    = chan.cmd.cy;
                    zx_next    = chan.cmd.cx;
                    zy_next    = chan.cmd.cy;
                    k_next     = '0;
                    hits_next  = '0;
                    esc_next   = 1'b0;
                    if (chan.cmd.kind)
                    begin
                        state_next = S_RRD;
                    end
                    else if (chan.cmd.skip)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                xx_next    = zx_reg * zx_reg;
                yy_next    = zy_reg * zy_reg;
                xy_next    = zx_reg * zy_reg;
                dx_next    = zy_reg * $signed({1'b0, cfg.scale_x});
                dy_next    = zx_reg * $signed({1'b0, cfg.scale_y});
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (r2 > FOUR_Q56)
                begin
                    esc_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    zx_next   = 32'(tx >>> 28) + cx_reg;
                    zy_next   = 32'(ty >>> 28) + cy_reg;
                    k_next    = k_reg + 1'b1;
                    addr_next = ADDR_W'(32'(py) * FRAME_W + 32'(px));
                    if ((k_reg > 17'(DRAW_AFTER)) && in_win)
                    begin
                        state_next = S_RD;
                    end
                    else if (k_reg >= {1'b0, cfg.max_iter})
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (hits_reg != 16'hFFFF)
                begin
                    hits_next = hits_reg + 1'b1;
                end
                state_next = (k_reg > {1'b0, cfg.max_iter}) ? S_DONE : S_MUL;
            end
            S_RRD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next    = 1'b1;
                    res_next.read_data = (kind_reg && rd_ok_reg) ? mem_q_reg : '0;
                    res_next.hits      = kind_reg ? '0 : hits_reg;
                    res_next.escaped   = kind_reg ? 1'b0 : esc_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        xy_reg    <= xy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        hits_reg  <= hits_next;
        esc_reg   <= esc_next;
        kind_reg  <= kind_next;
        rd_ok_reg <= rd_ok_next;
        addr_reg  <= addr_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= frame_mem[addr_reg];
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/sv/odacc_orbit_checker.sv
`timescale 1ns / 1ps
// Watches both queue ports and the register port, predicts every result and
// compares it with what the block delivers.
module odacc_orbit_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  odacc_pkg::in_item_t  in_item,
    input  logic                 full,
    input  logic                 pop,
    input  logic                 empty,
    input  odacc_pkg::out_item_t out_item,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   errors,
    output int                   pending,
    output int                   traces_seen,
    output int                   reads_seen,
    output logic [17:0]          last_hit_addr
);
    import odacc_pkg::*;

    bit [23:0]  frame_words [FRAME_WORDS];
    cfg_t       regs;
    out_item_t  expected_results [$];

    initial
    begin
        errors        = 0;
        traces_seen   = 0;
        reads_seen    = 0;
        last_hit_addr = '0;
        foreach (frame_words[a])
            frame_words[a] = '0;
    end

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    // Q.44 to a pixel coordinate, to nearest with ties away from zero.
    function automatic longint to_pixel(input longint v);
        longint half;
        half = longint'(1) <<< 43;
        if (v >= 0)
            return (v + half) >>> 44;
        return -((-v + half) >>> 44);
    endfunction

    // Maps one orbit point to the frame and accumulates it when it lands
    // strictly inside the window.
    function automatic bit plot_point(input longint zx, input longint zy);
        longint px;
        longint py;
        int     addr;
        bit [24:0] sum;
        px = to_pixel(zy * longint'({32'b0, regs.scale_x})
                      + (longint'(regs.offset_x) <<< 28));
        py = to_pixel((longint'(regs.offset_y) <<< 28)
                      - zx * longint'({32'b0, regs.scale_y}));
        if (!(px > longint'(regs.origin_x) && px < WIN_W && px < FRAME_W))
            return 0;
        if (!(py > longint'(regs.origin_y) && py < WIN_H && py < FRAME_H))
            return 0;
        addr = int'(py) * FRAME_W + int'(px);
        sum  = {1'b0, frame_words[addr]} + {1'b0, regs.brightness_step};
        frame_words[addr] = sum[24] ? WORD_MAX : sum[23:0];
        last_hit_addr = addr[17:0];
        return 1;
    endfunction

    function automatic out_item_t trace_orbit(input logic signed [31:0] re,
                                              input logic signed [31:0] im);
        out_item_t res;
        longint    cx;
        longint    cy;
        longint    zx;
        longint    zy;
        longint    xx;
        longint    yy;
        longint    xy;
        longint    two;
        longint    half;
        int        k;
        res  = '0;
        cx   = re;
        cy   = im;
        two  = longint'(TWO_Q28);
        half = longint'(1) <<< 27;
        if (cx < -two || cx > two || cy < -two || cy > two)
            return res;
        zx = cx;
        zy = cy;
        for (k = 0; k <= int'(regs.max_iter); k++)
        begin
            xx = zx * zx;
            yy = zy * zy;
            xy = zx * zy;
            if (xx + yy > (longint'(4) <<< 56))
            begin
                res.escaped = 1'b1;
                break;
            end
            if (k > DRAW_AFTER && plot_point(zx, zy) && res.hits != 16'hFFFF)
                res.hits++;
            zx = ((xx - yy + half) >>> 28) + cx;
            zy = ((2 * xy + half) >>> 28) + cy;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            regs.scale_x         <= 32'h0100_0000;
            regs.scale_y         <= 32'h0100_0000;
            regs.offset_x        <= 32'sh0100_0000;
            regs.offset_y        <= 32'sh0100_0000;
            regs.origin_x        <= '0;
            regs.origin_y        <= '0;
            regs.brightness_step <= 24'h010101;
            regs.max_iter        <= 16'd100;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCALE_X:  regs.scale_x         <= cfg_data;
                    CFG_SCALE_Y:  regs.scale_y         <= cfg_data;
                    CFG_OFFSET_X: regs.offset_x        <= cfg_data;
                    CFG_OFFSET_Y: regs.offset_y        <= cfg_data;
                    CFG_ORIGIN_X: regs.origin_x        <= cfg_data[8:0];
                    CFG_ORIGIN_Y: regs.origin_y        <= cfg_data[8:0];
                    CFG_BRIGHT:   regs.brightness_step <= cfg_data[23:0];
                    CFG_MAX_ITER: regs.max_iter        <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                if (in_item.kind)
                begin
                    exp_r = '0;
                    exp_r.read_data = frame_words[in_item.read_addr];
                    reads_seen++;
                end
                else
                begin
                    exp_r = trace_orbit(in_item.point_re, in_item.point_im);
                    traces_seen++;
                end
                expected_results.push_back(exp_r);
            end
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 0, out_item);
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_item.read_data !== exp_r.read_data)
                        report_mismatch("read_data", exp_r.read_data, out_item.read_data);
                    if (out_item.hits !== exp_r.hits)
                        report_mismatch("hits", exp_r.hits, out_item.hits);
                    if (out_item.escaped !== exp_r.escaped)
                        report_mismatch("escaped", exp_r.escaped, out_item.escaped);
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_orbit_density_accumulator_core.sv
`timescale 1ns / 1ps
// Top of the bench. It drives items and register writes into the block and
// pops results; all prediction and comparison lives in the checker beside it.
module tb_orbit_density_accumulator_core;
    import odacc_pkg::*;

    // An index past the last register; writes to it must change nothing.
    localparam logic [3:0] CFG_UNUSED = 4'd15;
    // The limit leaves ample room for stalls beyond the clear pass and the
    // deepest orbit phase.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam logic KIND_TRACE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        push;
    in_item_t    in_item;
    logic        full;
    logic        pop;
    logic        empty;
    out_item_t   out_item;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_data;

    int          errors;
    int          pending;
    int          traces_seen;
    int          reads_seen;
    logic [17:0] last_hit_addr;

    int          items_sent;
    int          cycles;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          phases_run;

    orbit_density_accumulator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    odacc_orbit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .in_item       (in_item),
        .full          (full),
        .pop           (pop),
        .empty         (empty),
        .out_item      (out_item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .traces_seen   (traces_seen),
        .reads_seen    (reads_seen),
        .last_hit_addr (last_hit_addr)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog. A hung block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("orbit_density_accumulator_core verification failed");
            $finish;
        end
    end

    // The receiver pops at random; the idle share follows the stimulus stage.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // The idle profile moves with the item count: first a slow sender and a
    // very slow receiver, then the reverse, then both run flat out.
    always @(items_sent)
    begin
        if (items_sent < 550)
        begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 63;
        end
        else if (items_sent < 1100)
        begin
            sender_idle_pct   = 63;
            receiver_idle_pct = 38;
        end
        else
        begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    end

    // Presents one item and holds it until the block takes it. full depends
    // only on registers, so it is looked at mid-cycle and the next rising
    // edge is the one that takes the item. push is left high on return so
    // back-to-back items need no gap.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    function automatic in_item_t make_trace(input logic signed [31:0] re,
                                            input logic signed [31:0] im);
        in_item_t it;
        it.kind      = KIND_TRACE;
        it.point_re  = re;
        it.point_im  = im;
        it.read_addr = 18'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_read(input logic [17:0] addr);
        in_item_t it;
        it.kind      = KIND_READ;
        it.point_re  = $urandom;
        it.point_im  = $urandom;
        it.read_addr = addr;
        return it;
    endfunction

    // Most start points sit in the main cardioid so that the orbit stays
    // bounded and runs long enough to draw; some spread over the legal square
    // and usually escape early, and a few are arbitrary words, mostly out of
    // range.
    function automatic in_item_t random_trace();
        int r;
        logic signed [31:0] re;
        logic signed [31:0] im;
        r = $urandom_range(99);
        if (r < 55)
        begin
            re = $signed($urandom_range(1 << 27)) - (1 << 26);
            im = $signed($urandom_range(1 << 27)) - (1 << 26);
        end
        else if (r < 85)
        begin
            re = $signed($urandom_range(1 << 30)) - (1 << 29);
            im = $signed($urandom_range(1 << 30)) - (1 << 29);
        end
        else
        begin
            re = $urandom;
            im = $urandom;
        end
        return make_trace(re, im);
    endfunction

    // Reads favor the most recently drawn word so that nonzero and saturated
    // words actually come back.
    function automatic in_item_t random_read();
        if ($urandom_range(1))
            return make_read(last_hit_addr);
        return make_read(18'($urandom));
    endfunction

    // Lets the block drain: every result back, then a short settling pause
    // before registers may change.
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes every register, then one write to an index that does not exist.
    // The enable is lowered once at the end so it never toggles within a step.
    task automatic load_regs(input cfg_t c);
        logic [3:0]  idx [9];
        logic [31:0] val [9];
        int i;
        idx = '{CFG_SCALE_X, CFG_SCALE_Y, CFG_OFFSET_X, CFG_OFFSET_Y, CFG_ORIGIN_X,
                CFG_ORIGIN_Y, CFG_BRIGHT, CFG_MAX_ITER, CFG_UNUSED};
        val = '{c.scale_x, c.scale_y, c.offset_x, c.offset_y, {23'b0, c.origin_x},
                {23'b0, c.origin_y}, {8'b0, c.brightness_step}, {16'b0, c.max_iter},
                $urandom};
        push <= 1'b0;
        drain();
        for (i = 0; i < 9; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    task automatic run_random(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
                send_item(random_trace());
            else
                send_item(random_read());
        end
    endtask

    // A view that puts the bounded part of the set on screen: gains of 16 to
    // 1024 pixels per unit and offsets of -64 to 448 pixels.
    function automatic cfg_t random_view();
        cfg_t c;
        c.scale_x         = $urandom_range(32'h0010_0000, 32'h0400_0000);
        c.scale_y         = $urandom_range(32'h0010_0000, 32'h0400_0000);
        c.offset_x        = $signed($urandom_range(32'h0200_0000)) - 32'sh0040_0000;
        c.offset_y        = $signed($urandom_range(32'h0200_0000)) - 32'sh0040_0000;
        c.origin_x        = 9'($urandom_range(200));
        c.origin_y        = 9'($urandom_range(200));
        c.brightness_step = ($urandom_range(3) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(16'hFFFF));
        c.max_iter        = ($urandom_range(4) == 0) ? 16'($urandom_range(50))
                                                      : 16'($urandom_range(51, 110));
        return c;
    endfunction

    initial
    begin
        cfg_t c;
        int   p;
        int   i;
        rst_n      = 1'b0;
        push       = 1'b0;
        in_item    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        items_sent = 0;
        cycles     = 0;
        phases_run = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset registers. The start points cover
        // the fixed point at zero, a period-two orbit, the edge of the legal
        // square on three sides, points just outside it, the extreme words,
        // and an orbit that escapes at once.
        send_item(make_trace(32'sd0, 32'sd0));
        send_item(make_trace(-32'sh1000_0000, 32'sd0));
        send_item(make_trace(-TWO_Q28, 32'sd0));
        send_item(make_trace(TWO_Q28, 32'sd0));
        send_item(make_trace(32'sd0, -TWO_Q28));
        send_item(make_trace(TWO_Q28 + 32'sd1, 32'sd0));
        send_item(make_trace(32'sd0, -TWO_Q28 - 32'sd1));
        send_item(make_trace(32'sh7FFF_FFFF, 32'sh8000_0000));
        send_item(make_trace(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_item(make_trace(-32'sh0199_999A, 32'sh0199_999A));
        send_item(make_trace(32'sh0400_0000, 32'sd0));
        send_item(make_trace(-32'sh0C00_0000, 32'sh0010_0000));
        send_item(make_read(last_hit_addr));
        send_item(make_read(18'd0));
        send_item(make_read(18'h3FFFF));

        // Full brightness: the first hit saturates a word and later hits
        // keep it there while still counting.
        c = random_view();
        c.brightness_step = WORD_MAX;
        c.max_iter        = 16'd100;
        c.origin_x        = '0;
        c.origin_y        = '0;
        load_regs(c);
        for (i = 0; i < 6; i++)
        begin
            send_item(make_trace(32'sd0, 32'sd0));
            send_item(make_trace(-32'sh1000_0000, 32'sd0));
            send_item(make_read(last_hit_addr));
        end

        // Register extremes: zero gains pin every point to the offset pixel,
        // a window edge at the far corner draws nothing, and the iteration limit is zero.
        c.scale_x         = '0;
        c.scale_y         = '0;
        c.offset_x        = 32'sh0100_8000;
        c.offset_y        = 32'sh00FF_8000;
        c.brightness_step = '0;
        load_regs(c);
        run_random(20);
        c.scale_x         = 32'hFFFF_FFFF;
        c.scale_y         = 32'hFFFF_FFFF;
        c.offset_x        = 32'sh8000_0000;
        c.offset_y        = 32'sh7FFF_FFFF;
        c.origin_x        = 9'd511;
        c.origin_y        = 9'd511;
        c.brightness_step = 24'd1;
        c.max_iter        = '0;
        load_regs(c);
        run_random(20);

        // Deepest orbit allowed, on a few bounded and escaping points only.
        c = random_view();
        c.max_iter = 16'hFFFF;
        load_regs(c);
        send_item(make_trace(32'sd0, 32'sd0));
        send_item(make_trace(-32'sh1000_0000, 32'sd0));
        send_item(make_trace(TWO_Q28, TWO_Q28));
        send_item(make_read(last_hit_addr));

        // Random views, each with a burst of mixed items.
        for (p = 0; p < 8; p++)
        begin
            load_regs(random_view());
            run_random(190);
        end

        push <= 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d orbit traces and %0d frame reads over %0d register settings",
                 traces_seen, reads_seen, phases_run);
        $display("idle profiles: slow sender, slow receiver, then no idling");
        if (errors == 0 && pending == 0)
            $display("orbit_density_accumulator_core verification clean");
        else
            $display("orbit_density_accumulator_core verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/odacc_pkg.sv
sv/odacc_front.sv
sv/odacc_orbit.sv
sv/orbit_density_accumulator_core.sv
tb/sv/odacc_orbit_checker.sv
tb/sv/tb_orbit_density_accumulator_core.sv
